// ===== hdl/e20_pkg.sv =====
// ----------------------------------------------------------------------------
// e20_pkg: shared types and constants for the sixteen-bit processor core
// Instruction fields, opcodes, function codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package e20_pkg;

    localparam int MEM_WORDS  = 8192;
    localparam int REG_COUNT  = 8;
    localparam int WORD_W     = 16;
    localparam int ADDR_W     = $clog2(MEM_WORDS);
    localparam int REG_IDX_W  = $clog2(REG_COUNT);

    localparam logic [REG_IDX_W-1:0] LINK_REG = REG_IDX_W'(REG_COUNT - 1);
    localparam logic [ADDR_W-1:0]    ADDR_MAX = ADDR_W'(MEM_WORDS - 1);

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [REG_IDX_W-1:0] t_ridx;

    // Input item selector
    localparam logic OPER_LOAD = 1'b0;
    localparam logic OPER_STEP = 1'b1;

    // Opcodes (bits 15:13)
    localparam logic [2:0] OPC_RRR  = 3'd0;
    localparam logic [2:0] OPC_ADDI = 3'd1;
    localparam logic [2:0] OPC_J    = 3'd2;
    localparam logic [2:0] OPC_JAL  = 3'd3;
    localparam logic [2:0] OPC_LW   = 3'd4;
    localparam logic [2:0] OPC_SW   = 3'd5;
    localparam logic [2:0] OPC_JEQ  = 3'd6;
    localparam logic [2:0] OPC_SLTI = 3'd7;

    // Function codes of the three-register form (bits 3:0)
    localparam logic [3:0] FN_ADD = 4'd0;
    localparam logic [3:0] FN_SUB = 4'd1;
    localparam logic [3:0] FN_OR  = 4'd2;
    localparam logic [3:0] FN_AND = 4'd3;
    localparam logic [3:0] FN_SLT = 4'd4;
    localparam logic [3:0] FN_JR  = 4'd8;

    typedef struct packed {
        t_word mem_write_value;
        t_addr mem_write_address;
        logic  mem_write_valid;
        t_word reg_write_value;
        t_ridx reg_write_index;
        logic  reg_write_valid;
        logic  halted;
        t_addr pc_after;
    } t_result;

    function automatic t_word sext7(input t_word ins);
        sext7 = {{(WORD_W-7){ins[6]}}, ins[6:0]};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sixteen_bit_eight_register_cpu_core.sv =====
// A step item runs through the decode and execute states, and the memory state for lw,
// before the result state; a load item or a step while halted goes straight to the result state.
// Items are taken one at a time, paced by the single-port main memory (fetch, then data
// access), the registered register-file read and back-pressure on the output register.
// Reset (i_rst_n low, synchronous) starts a clearing pass over all 8192 memory addresses
// that zeroes memory and registers; no beat is accepted meanwhile.
// ----------------------------------------------------------------------------
// sixteen_bit_eight_register_cpu_core: sixteen-bit, eight-register processor
// Unified 8192-word memory; load beats write program words, step beats
// execute one instruction through a fetch/decode/execute/memory sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sixteen_bit_eight_register_cpu_core
    import e20_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // load_address[12:0], load_word[28:13], zero pad
    input  wire logic        i_s_axis_tuser,  // operation[0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata   // pc_after[12:0], halted[13],
                                              // reg_write_valid[14], reg_write_index[17:15],
                                              // reg_write_value[33:18], mem_write_valid[34],
                                              // mem_write_address[47:35], mem_write_value[63:48]
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_MEM,
        ST_RESP
    } t_state;

    t_state  r_state;
    t_addr   r_pc;
    logic    r_halt;
    logic    r_clr_busy;
    t_addr   r_clr_cnt;
    t_word   r_ins;
    t_ridx   r_lw_rdst;
    t_result r_res;
    t_result r_out;
    logic    r_out_valid;

    t_word r_mem [MEM_WORDS];
    t_word r_mem_q;
    t_word r_rf [REG_COUNT];
    t_word r_rf_a;
    t_word r_rf_b;

    logic  mem_we;
    t_addr mem_addr;
    t_word mem_wdata;
    logic  rf_we;
    t_ridx rf_waddr;
    t_word rf_wdata;
    t_ridx rf_ra;
    t_ridx rf_rb;

    logic  in_beat;
    t_addr in_addr;
    t_word in_word;
    logic  out_load;

    // Execute-stage decode and results
    logic [2:0] ex_opc;
    logic [3:0] ex_fn;
    t_word ex_imm;
    t_addr ex_pc1;
    t_addr ex_ea;
    logic  ex_rw;
    t_ridx ex_rdst;
    t_word ex_rval;
    logic  ex_mw;
    t_addr ex_next;
    logic  ex_halt;
    t_word ex_sum;

    assign o_s_axis_tready = (r_state == ST_IDLE) && !r_clr_busy;
    assign in_beat = i_s_axis_tvalid && o_s_axis_tready;
    assign in_addr = i_s_axis_tdata[ADDR_W-1:0];
    assign in_word = i_s_axis_tdata[ADDR_W+WORD_W-1:ADDR_W];
    assign out_load = (r_state == ST_RESP) && (!r_out_valid || i_m_axis_tready);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.mem_write_value, r_out.mem_write_address,
                              r_out.mem_write_valid, r_out.reg_write_value,
                              r_out.reg_write_index, r_out.reg_write_valid,
                              r_out.halted, r_out.pc_after};

    always_comb begin
        ex_opc  = r_ins[15:13];
        ex_fn   = r_ins[3:0];
        ex_imm  = sext7(r_ins);
        ex_pc1  = r_pc + t_addr'(1);
        ex_sum  = r_rf_a + ex_imm;
        ex_ea   = ex_sum[ADDR_W-1:0];
        ex_rw   = 1'b0;
        ex_rdst = r_ins[9:7];
        ex_rval = '0;
        ex_mw   = 1'b0;
        ex_next = ex_pc1;
        ex_halt = 1'b0;
        case (ex_opc)
            OPC_RRR: begin
                ex_rdst = r_ins[6:4];
                case (ex_fn)
                    FN_ADD: begin ex_rw = 1'b1; ex_rval = r_rf_a + r_rf_b; end
                    FN_SUB: begin ex_rw = 1'b1; ex_rval = r_rf_a - r_rf_b; end
                    FN_OR:  begin ex_rw = 1'b1; ex_rval = r_rf_a | r_rf_b; end
                    FN_AND: begin ex_rw = 1'b1; ex_rval = r_rf_a & r_rf_b; end
                    FN_SLT: begin
                        ex_rw   = 1'b1;
                        ex_rval = t_word'(r_rf_a < r_rf_b);
                    end
                    FN_JR:  ex_next = r_rf_a[ADDR_W-1:0];
                    default: ;
                endcase
            end
            OPC_ADDI: begin ex_rw = 1'b1; ex_rval = ex_sum; end
            OPC_J: begin
                if (r_ins[ADDR_W-1:0] == r_pc) begin
                    ex_halt = 1'b1;
                    ex_next = r_pc;
                end else begin
                    ex_next = r_ins[ADDR_W-1:0];
                end
            end
            OPC_JAL: begin
                ex_rdst = LINK_REG;
                ex_rw   = 1'b1;
                ex_rval = t_word'(ex_pc1);
                ex_next = r_ins[ADDR_W-1:0];
            end
            OPC_LW: ;
            OPC_SW: ex_mw = 1'b1;
            OPC_JEQ: begin
                if (r_rf_a == r_rf_b) ex_next = ex_pc1 + ex_imm[ADDR_W-1:0];
            end
            default: begin
                ex_rw   = 1'b1;
                ex_rval = t_word'(r_rf_a < ex_imm);
            end
        endcase
        if (ex_rdst == '0) ex_rw = 1'b0;
    end

    // Memory and register-file port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_pc;
        mem_wdata = '0;
        rf_we     = 1'b0;
        rf_waddr  = r_lw_rdst;
        rf_wdata  = r_mem_q;
        rf_ra     = r_mem_q[12:10];
        rf_rb     = r_mem_q[9:7];
        if (r_clr_busy) begin
            mem_we   = 1'b1;
            mem_addr = r_clr_cnt;
            rf_we    = 1'b1;
            rf_waddr = r_clr_cnt[REG_IDX_W-1:0];
            rf_wdata = '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_beat && i_s_axis_tuser == OPER_LOAD) begin
                        mem_we    = 1'b1;
                        mem_addr  = in_addr;
                        mem_wdata = in_word;
                    end
                end
                ST_EXEC: begin
                    mem_addr  = ex_ea;
                    mem_wdata = r_rf_b;
                    mem_we    = ex_mw;
                    rf_we     = ex_rw;
                    rf_waddr  = ex_rdst;
                    rf_wdata  = ex_rval;
                end
                ST_MEM: rf_we = (r_lw_rdst != '0);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        r_mem_q <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) r_rf[rf_waddr] <= rf_wdata;
        r_rf_a <= r_rf[rf_ra];
        r_rf_b <= r_rf[rf_rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + t_addr'(1);
                if (r_clr_cnt == ADDR_MAX) r_clr_busy <= 1'b0;
            end

            if (out_load) r_out_valid <= 1'b1;
            else if (i_m_axis_tready) r_out_valid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_res.pc_after        <= r_pc;
                        r_res.halted          <= r_halt;
                        r_res.reg_write_valid <= 1'b0;
                        r_res.reg_write_index <= '0;
                        r_res.reg_write_value <= '0;
                        if (i_s_axis_tuser == OPER_LOAD) begin
                            r_res.mem_write_valid   <= 1'b1;
                            r_res.mem_write_address <= in_addr;
                            r_res.mem_write_value   <= in_word;
                            r_state <= ST_RESP;
                        end else begin
                            r_res.mem_write_valid   <= 1'b0;
                            r_res.mem_write_address <= '0;
                            r_res.mem_write_value   <= '0;
                            if (r_halt) r_state <= ST_RESP;
                            else r_state <= ST_DECODE;
                        end
                    end
                end
                ST_DECODE: begin
                    r_ins   <= r_mem_q;
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (ex_opc == OPC_LW) begin
                        r_lw_rdst <= ex_rdst;
                        r_pc      <= ex_pc1;
                        r_state   <= ST_MEM;
                    end else begin
                        r_pc   <= ex_next;
                        r_halt <= r_halt | ex_halt;
                        r_res.pc_after          <= ex_next;
                        r_res.halted            <= r_halt | ex_halt;
                        r_res.reg_write_valid   <= ex_rw;
                        r_res.reg_write_index   <= ex_rw ? ex_rdst : '0;
                        r_res.reg_write_value   <= ex_rw ? ex_rval : '0;
                        r_res.mem_write_valid   <= ex_mw;
                        r_res.mem_write_address <= ex_mw ? ex_ea : '0;
                        r_res.mem_write_value   <= ex_mw ? r_rf_b : '0;
                        r_state <= ST_RESP;
                    end
                end
                ST_MEM: begin
                    r_res.pc_after        <= r_pc;
                    r_res.halted          <= r_halt;
                    r_res.reg_write_valid <= (r_lw_rdst != '0);
                    r_res.reg_write_index <= r_lw_rdst;
                    r_res.reg_write_value <= (r_lw_rdst != '0) ? r_mem_q : '0;
                    r_state <= ST_RESP;
                end
                ST_RESP: begin
                    // hold the result until the output register frees up
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_no_beat_while_clearing: assert property (@(posedge i_clk)
        r_clr_busy |-> !o_s_axis_tready)
        else $error("input beat offered during clearing pass");

    a_r0_never_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rf_we && !r_clr_busy) |-> (rf_waddr != '0))
        else $error("write to r0 outside clearing pass");

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag dropped");

    a_pc_frozen_when_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> $stable(r_pc))
        else $error("pc moved while halted");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_s_axis_tready)
        else $error("input ready while an item is in flight");

endmodule

`default_nettype wire
